@@ hdl/gclu_pkg.sv @@
package gclu_pkg;

    localparam int OPERAND_PORT_WIDTH = 32;
    localparam int ANSWER_WIDTH       = 64;

    localparam logic CMD_GCD = 1'b0;
    localparam logic CMD_LCM = 1'b1;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

endpackage

@@ hdl/gclu_alu.sv @@
module gclu_alu #(
    parameter int AW = 64
) (
    input  logic [AW-1:0]           i_x,
    input  logic [AW-1:0]           i_y,
    input  gclu_pkg::t_alu_op       i_op,
    output logic [AW-1:0]           o_sum,
    output logic                    o_carry
);
    import gclu_pkg::*;

    logic [AW-1:0] y_eff;
    logic [AW:0]   total;

    // subtract as x + ~y + 1; carry out set means x >= y
    assign y_eff = (i_op == ALU_SUB) ? ~i_y : i_y;
    assign total = {1'b0, i_x} + {1'b0, y_eff} + {{AW{1'b0}}, (i_op == ALU_SUB)};
    assign o_sum   = total[AW-1:0];
    assign o_carry = total[AW];

endmodule

@@ hdl/gcd_lcm_unit.sv @@
// gcd / lcm unit. A command is taken when start is high and busy is low; the
// result appears on o_answer and o_zero_operand for exactly one cycle with
// o_done high and must be captured then, since the receiver cannot stall it.
// Only the low OPERAND_WIDTH bits of each operand are used. A zero operand
// goes straight to the output state. Otherwise the binary gcd runs and then
// shifts back the common factors of two, and an lcm adds restoring division
// (first operand by the gcd) and a shift-add multiply by the second operand.
// The gcd subtract, divide and multiply steps go through one shared
// 2*OPERAND_WIDTH-bit adder.
module gcd_lcm_unit #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cmd,
    input  logic [31:0] i_first_operand,
    input  logic [31:0] i_second_operand,
    output logic        o_done,
    output logic [63:0] o_answer,
    output logic        o_zero_operand
);
    import gclu_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int DW = 2 * OPERAND_WIDTH;
    localparam int KW = $clog2(OPERAND_WIDTH);
    localparam int CW = $clog2(OPERAND_WIDTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_GCD,
        S_GSHIFT,
        S_DIV,
        S_MUL,
        S_OUT
    } t_state;

    t_state        r_state, n_state;
    logic          r_cmd, n_cmd;
    logic          r_zero, n_zero;
    logic [W-1:0]  r_opa, n_opa;
    logic [W-1:0]  r_opb, n_opb;
    logic [W-1:0]  r_a, n_a;
    logic [W-1:0]  r_b, n_b;
    logic [KW-1:0] r_k, n_k;
    logic [W-1:0]  r_g, n_g;
    logic [W-1:0]  r_rem, n_rem;
    logic [W-1:0]  r_q, n_q;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [DW-1:0] r_mcand, n_mcand;
    logic [DW-1:0] r_acc, n_acc;
    logic [DW-1:0] r_answer, n_answer;

    logic [W-1:0]  in_a, in_b;
    logic [W:0]    shifted;
    logic [DW-1:0] alu_x, alu_y, alu_sum;
    t_alu_op       alu_op;
    logic          alu_carry;

    gclu_alu #(.AW(DW)) u_alu (
        .i_x     (alu_x),
        .i_y     (alu_y),
        .i_op    (alu_op),
        .o_sum   (alu_sum),
        .o_carry (alu_carry)
    );

    assign in_a    = i_first_operand[W-1:0];
    assign in_b    = i_second_operand[W-1:0];
    assign shifted = {r_rem, r_a[W-1]};

    // operand select for the shared adder
    always_comb begin
        alu_x  = DW'(r_a);
        alu_y  = DW'(r_b);
        alu_op = ALU_SUB;
        case (r_state)
            S_DIV: begin
                alu_x  = DW'(shifted);
                alu_y  = DW'(r_g);
                alu_op = ALU_SUB;
            end
            S_MUL: begin
                alu_x  = r_acc;
                alu_y  = r_mcand;
                alu_op = ALU_ADD;
            end
            default: begin
                alu_x  = DW'(r_a);
                alu_y  = DW'(r_b);
                alu_op = ALU_SUB;
            end
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_zero   = r_zero;
        n_opa    = r_opa;
        n_opb    = r_opb;
        n_a      = r_a;
        n_b      = r_b;
        n_k      = r_k;
        n_g      = r_g;
        n_rem    = r_rem;
        n_q      = r_q;
        n_cnt    = r_cnt;
        n_mcand  = r_mcand;
        n_acc    = r_acc;
        n_answer = r_answer;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd  = i_cmd;
                    n_opa  = in_a;
                    n_opb  = in_b;
                    n_a    = in_a;
                    n_b    = in_b;
                    n_k    = '0;
                    n_zero = (in_a == '0) || (in_b == '0);
                    if ((in_a == '0) || (in_b == '0)) begin
                        // gcd is the nonzero one (or 0), lcm is 0
                        n_answer = (i_cmd == CMD_GCD) ? DW'(in_a | in_b) : '0;
                        n_state  = S_OUT;
                    end else begin
                        n_state = S_GCD;
                    end
                end
            end
            S_GCD: begin
                if (r_a == r_b) begin
                    n_g     = r_a;
                    n_state = S_GSHIFT;
                end else if (!r_a[0] && !r_b[0]) begin
                    n_a = r_a >> 1;
                    n_b = r_b >> 1;
                    n_k = r_k + KW'(1);
                end else if (!r_a[0]) begin
                    n_a = r_a >> 1;
                end else if (!r_b[0]) begin
                    n_b = r_b >> 1;
                end else if (alu_carry) begin
                    // both odd, a > b: difference is even
                    n_a = {1'b0, alu_sum[W-1:1]};
                end else begin
                    n_a = r_b;
                    n_b = r_a;
                end
            end
            S_GSHIFT: begin
                if (r_k != '0) begin
                    n_g = r_g << 1;
                    n_k = r_k - KW'(1);
                end else if (r_cmd == CMD_GCD) begin
                    n_answer = DW'(r_g);
                    n_state  = S_OUT;
                end else begin
                    n_a     = r_opa;
                    n_rem   = '0;
                    n_q     = '0;
                    n_cnt   = CW'(W);
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_a = r_a << 1;
                if (alu_carry) begin
                    n_rem = alu_sum[W-1:0];
                    n_q   = {r_q[W-2:0], 1'b1};
                end else begin
                    n_rem = shifted[W-1:0];
                    n_q   = {r_q[W-2:0], 1'b0};
                end
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    n_mcand = DW'(n_q);
                    n_acc   = '0;
                    n_b     = r_opb;
                    n_cnt   = CW'(W);
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (r_b[0]) begin
                    n_acc = alu_sum;
                end
                n_mcand = r_mcand << 1;
                n_b     = r_b >> 1;
                n_cnt   = r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    n_answer = n_acc;
                    n_state  = S_OUT;
                end
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_cmd    <= n_cmd;
        r_zero   <= n_zero;
        r_opa    <= n_opa;
        r_opb    <= n_opb;
        r_a      <= n_a;
        r_b      <= n_b;
        r_k      <= n_k;
        r_g      <= n_g;
        r_rem    <= n_rem;
        r_q      <= n_q;
        r_cnt    <= n_cnt;
        r_mcand  <= n_mcand;
        r_acc    <= n_acc;
        r_answer <= n_answer;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_done         = (r_state == S_OUT);
    assign o_answer       = ANSWER_WIDTH'(r_answer);
    assign o_zero_operand = r_zero;

endmodule

@@ tb/sv/gcd_lcm_unit_test.sv @@
module gcd_lcm_unit_test;
    import gclu_pkg::*;

    localparam int OPW          = OPERAND_PORT_WIDTH;
    localparam int NUM_RANDOM   = 1800;
    localparam int NUM_EDGE     = 12;
    localparam int DRAIN_CYCLES = 400;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic                    i_cmd;
    logic [OPW-1:0]          i_first_operand;
    logic [OPW-1:0]          i_second_operand;
    logic                    o_done;
    logic [ANSWER_WIDTH-1:0] o_answer;
    logic                    o_zero_operand;

    int unsigned gcd_count;
    int unsigned lcm_count;
    int unsigned zero_count;
    bit          steady_run;

    typedef struct {
        logic                    cmd;
        logic [OPW-1:0]          a;
        logic [OPW-1:0]          b;
        logic [ANSWER_WIDTH-1:0] answer;
        logic                    zero_operand;
    } t_pending_answer;

    class gcd_lcm_checker;
        t_pending_answer pending_answers[$];
        int unsigned     mismatches;
        int unsigned     checked;

        static function logic [63:0] common_divisor(logic [63:0] x, logic [63:0] y);
            logic [63:0] r;
            while (y != 0) begin
                r = x % y;
                x = y;
                y = r;
            end
            return x;
        endfunction

        function void note_command(logic cmd, logic [OPW-1:0] a, logic [OPW-1:0] b);
            t_pending_answer e;
            logic [63:0]     g;
            g              = common_divisor(64'(a), 64'(b));
            e.cmd          = cmd;
            e.a            = a;
            e.b            = b;
            e.zero_operand = (a == 0) || (b == 0);
            if (cmd == CMD_GCD) begin
                e.answer = g;
            end else if (e.zero_operand) begin
                e.answer = '0;
            end else begin
                e.answer = (64'(a) / g) * 64'(b);
            end
            pending_answers.push_back(e);
        endfunction

        function void check_answer(logic [ANSWER_WIDTH-1:0] answer, logic zero_operand);
            t_pending_answer e;
            if (pending_answers.size() == 0) begin
                mismatches++;
                $display("%0t: result with no command pending, answer %h zero_operand %b",
                         $time, answer, zero_operand);
                return;
            end
            e = pending_answers.pop_front();
            checked++;
            if (answer !== e.answer) begin
                mismatches++;
                $display("%0t: answer (cmd %0d, %h, %h) expected %h actual %h",
                         $time, e.cmd, e.a, e.b, e.answer, answer);
            end
            if (zero_operand !== e.zero_operand) begin
                mismatches++;
                $display("%0t: zero_operand (cmd %0d, %h, %h) expected %b actual %b",
                         $time, e.cmd, e.a, e.b, e.zero_operand, zero_operand);
            end
        endfunction
    endclass

    gcd_lcm_checker board;

    gcd_lcm_unit #(
        .OPERAND_WIDTH(OPW)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cmd           (i_cmd),
        .i_first_operand (i_first_operand),
        .i_second_operand(i_second_operand),
        .o_done          (o_done),
        .o_answer        (o_answer),
        .o_zero_operand  (o_zero_operand)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // values seen here are the ones from before the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done === 1'b1) begin
                board.check_answer(o_answer, o_zero_operand);
            end
            if (start === 1'b1 && busy === 1'b0) begin
                board.note_command(i_cmd, i_first_operand, i_second_operand);
                if (i_cmd == CMD_GCD) begin
                    gcd_count++;
                end else begin
                    lcm_count++;
                end
                if (i_first_operand == 0 || i_second_operand == 0) begin
                    zero_count++;
                end
            end
        end
    end

    task automatic send_command(input logic cmd, input logic [OPW-1:0] a,
                                input logic [OPW-1:0] b);
        start            <= 1'b1;
        i_cmd            <= cmd;
        i_first_operand  <= a;
        i_second_operand <= b;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    task automatic idle_gap();
        int unsigned pick;
        int unsigned n;
        pick = $urandom_range(99);
        if (steady_run || pick < 45) begin
            n = 0;
        end else if (pick < 90) begin
            n = $urandom_range(3, 1);
        end else begin
            n = $urandom_range(150, 10);
        end
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic edge_pair(input int idx, output logic [OPW-1:0] a,
                             output logic [OPW-1:0] b);
        case (idx)
            0:       begin a = '0;            b = '0;            end
            1:       begin a = '0;            b = '1;            end
            2:       begin a = '1;            b = '0;            end
            3:       begin a = 32'd12345;     b = '0;            end
            4:       begin a = '0;            b = 32'd1;         end
            5:       begin a = '1;            b = '1;            end
            6:       begin a = 32'd1;         b = 32'd1;         end
            7:       begin a = '1;            b = 32'hFFFF_FFFE; end
            8:       begin a = 32'd1;         b = '1;            end
            9:       begin a = 32'h8000_0000; b = 32'h8000_0000; end
            10:      begin a = 32'h8000_0000; b = 32'h4000_0000; end
            default: begin a = 32'hFFFF_0000; b = 32'h0000_FFFF; end
        endcase
    endtask

    task automatic pick_operands(output logic [OPW-1:0] a, output logic [OPW-1:0] b);
        int unsigned    kind;
        logic [OPW-1:0] g;
        kind = $urandom_range(99);
        if (kind < 30) begin
            a = $urandom;
            b = $urandom;
        end else if (kind < 55) begin
            // common factor of up to 2**16 so the gcd is usually nontrivial
            g = $urandom_range(1 << $urandom_range(16, 1), 1);
            a = g * $urandom_range(32'hFFFF_FFFF / g, 1);
            b = g * $urandom_range(32'hFFFF_FFFF / g, 1);
        end else if (kind < 70) begin
            a = $urandom_range(1000);
            b = $urandom_range(1000);
        end else if (kind < 80) begin
            // shared powers of two
            a = $urandom_range(255, 1) << $urandom_range(24);
            b = $urandom_range(255, 1) << $urandom_range(24);
        end else if (kind < 88) begin
            a = $urandom;
            b = a;
        end else if (kind < 94) begin
            a = $urandom;
            b = '0;
            if ($urandom_range(1)) begin
                b = a;
                a = '0;
            end
        end else begin
            a = '1 - $urandom_range(15);
            b = '1 - $urandom_range(15);
        end
    endtask

    initial begin
        logic [OPW-1:0] a;
        logic [OPW-1:0] b;
        logic           cmd;
        board            = new;
        steady_run       = 1'b0;
        i_rst_n          = 1'b0;
        start            = 1'b0;
        i_cmd            = CMD_GCD;
        i_first_operand  = '0;
        i_second_operand = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < NUM_EDGE; i++) begin
            edge_pair(i, a, b);
            send_command(CMD_GCD, a, b);
            idle_gap();
            send_command(CMD_LCM, a, b);
            idle_gap();
        end

        for (int i = 0; i < NUM_RANDOM; i++) begin
            // some stretches go back to back with no idle cycles
            if (i % 150 == 0) begin
                steady_run = ($urandom_range(2) == 0);
            end
            cmd = $urandom_range(1) ? CMD_LCM : CMD_GCD;
            pick_operands(a, b);
            send_command(cmd, a, b);
            idle_gap();
        end
        start <= 1'b0;

        while (board.pending_answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d gcd and %0d lcm commands, %0d of them with a zero operand",
                 gcd_count, lcm_count, zero_count);
        $display("%0d answers compared, %0d field mismatches", board.checked,
                 board.mismatches);
        if (board.mismatches == 0 && board.pending_answers.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("timed out with %0d answers outstanding", board.pending_answers.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
